/* rtl/modular_arithmetic_unit_macros.svh */
// Assertion macros for the modular arithmetic unit.
// Depends on a clock aclk and an active-low reset aresetn in the using module.
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

`define MAU_CHECK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("modular arithmetic unit check failed");

`define MAU_NEVER(lbl, expr) \
    `MAU_CHECK(lbl, !(expr))

`endif

/* rtl/mau_pkg.sv */
// Package of the modular arithmetic unit: payload structs, codes and the
// request type of the shared arithmetic unit. Depends on nothing.
package mau_pkg;

    localparam logic [30:0] RESET_MODULUS = 31'd998244353;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_SUB    = 3'd1,
        ACT_MUL    = 3'd2,
        ACT_DIV    = 3'd3,
        ACT_NEG    = 3'd4,
        ACT_INV    = 3'd5,
        ACT_POW    = 3'd6,
        ACT_REDUCE = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_INV  = 2'd1,
        ST_NEG_EXP = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        UOP_MADD = 2'd0,
        UOP_MSUB = 2'd1,
        UOP_RSUB = 2'd2
    } unit_op_t;

    typedef struct packed {
        unit_op_t    op;
        logic [31:0] x;
        logic [31:0] y;
    } unit_req_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [30:0]        left_operand;
        logic [30:0]        right_operand;
        logic signed [63:0] wide_operand;
    } in_item_t;

    typedef struct packed {
        logic [30:0] residue_result;
        logic [1:0]  status;
    } out_item_t;

endpackage

/* rtl/mau_unit.sv */
// Shared arithmetic unit: modular add, modular subtract and raw subtract.
// Depends on mau_pkg.
module mau_unit import mau_pkg::*; (
    input  unit_req_t   req,
    input  logic [30:0] modulus,
    output logic [31:0] result,
    output logic        borrow
);

    logic [32:0] sum;
    logic [32:0] diff;
    logic [32:0] mod_ext;

    always_comb begin
        mod_ext = {2'b00, modulus};
        sum     = {1'b0, req.x} + {1'b0, req.y};
        diff    = {1'b0, req.x} - {1'b0, req.y};
        borrow  = diff[32];
        unique case (req.op)
            UOP_MADD: begin
                if (sum >= mod_ext) begin
                    result = 32'(sum - mod_ext);
                end else begin
                    result = sum[31:0];
                end
            end
            UOP_MSUB: begin
                if (diff[32]) begin
                    result = 32'(diff + mod_ext);
                end else begin
                    result = diff[31:0];
                end
            end
            default: begin
                result = diff[31:0];
            end
        endcase
    end

endmodule

/* rtl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: request sequencer and registers.
// Depends on mau_pkg, mau_unit and modular_arithmetic_unit_macros.svh.
//
// Usage: a request enters on s_valid/s_ready with s_data and yields one
// result on m_valid/m_ready with m_data. The modulus is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, which the block itself does not enforce. Reset loads 998244353.
// One request is worked at a time; s_ready is high only while idle.
// Add, sub, neg and range errors are settled in the check state. Mul
// runs double-and-add over the multiplier bits; power runs
// square-and-multiply over the exponent bits. Inverse runs extended
// Euclid by shifted subtractions; div adds one multiply. Reduce does
// double-and-add over the magnitude bits. All arithmetic goes through
// one shared add/subtract unit with a compare-and-correct step.
// When the receiver stalls, a finished result waits in the output
// register and the next request is accepted meanwhile; it waits at its
// end until the output register is free.
// Reset clears the sequencer and the output valid.
`include "modular_arithmetic_unit_macros.svh"
module modular_arithmetic_unit import mau_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_CHECK   = 15'b000000000000010,
        S_MUL_D   = 15'b000000000000100,
        S_MUL_A   = 15'b000000000001000,
        S_EU_TEST = 15'b000000000010000,
        S_EU_GROW = 15'b000000000100000,
        S_EU_DBL  = 15'b000000001000000,
        S_EU_SUB  = 15'b000000010000000,
        S_EU_SUBC = 15'b000000100000000,
        S_EU_END  = 15'b000001000000000,
        S_PW_TEST = 15'b000010000000000,
        S_RED_D   = 15'b000100000000000,
        S_RED_A   = 15'b001000000000000,
        S_RED_END = 15'b010000000000000,
        S_DONE    = 15'b100000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [30:0] mod_reg;
    in_item_t    item_reg, item_next;
    logic [31:0] s_reg, s_next, t_reg, t_next, ts_reg, ts_next;
    logic [30:0] c0_reg, c0_next, c1_reg, c1_next, cs_reg, cs_next;
    logic [30:0] mx_reg, mx_next, my_reg, my_next, acc_reg, acc_next;
    logic [30:0] r_reg, r_next, x_reg, x_next;
    logic [63:0] e_reg, e_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        phase_reg, phase_next;
    logic [30:0] res_reg, res_next;
    status_t     st_reg, st_next;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    unit_req_t   ureq;
    logic [31:0] ures;
    logic        uborrow;
    logic [30:0] one_mod;
    logic        a_bad, b_bad;

    mau_unit u_unit (
        .req     (ureq),
        .modulus (mod_reg),
        .result  (ures),
        .borrow  (uborrow)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign one_mod = (mod_reg == 31'd1) ? 31'd0 : 31'd1;
    assign a_bad   = (item_reg.left_operand >= mod_reg);
    assign b_bad   = (item_reg.right_operand >= mod_reg);

    always_comb begin
        ureq = '{op: UOP_RSUB, x: 32'd0, y: 32'd0};
        unique case (state_reg)
            S_CHECK: begin
                unique case (action_t'(item_reg.action))
                    ACT_ADD: ureq = '{op: UOP_MADD, x: {1'b0, item_reg.left_operand},
                                      y: {1'b0, item_reg.right_operand}};
                    ACT_SUB: ureq = '{op: UOP_MSUB, x: {1'b0, item_reg.left_operand},
                                      y: {1'b0, item_reg.right_operand}};
                    default: ureq = '{op: UOP_MSUB, x: 32'd0,
                                      y: {1'b0, item_reg.left_operand}};
                endcase
            end
            S_MUL_D:   ureq = '{op: UOP_MADD, x: {1'b0, acc_reg}, y: {1'b0, acc_reg}};
            S_MUL_A:   ureq = '{op: UOP_MADD, x: {1'b0, acc_reg},
                                y: my_reg[cnt_reg[4:0]] ? {1'b0, mx_reg} : 32'd0};
            S_EU_TEST: ureq = '{op: UOP_RSUB, x: s_reg, y: t_reg};
            S_EU_GROW: ureq = '{op: UOP_RSUB, x: s_reg, y: {ts_reg[30:0], 1'b0}};
            S_EU_DBL:  ureq = '{op: UOP_MADD, x: {1'b0, cs_reg}, y: {1'b0, cs_reg}};
            S_EU_SUB:  ureq = '{op: UOP_RSUB, x: s_reg, y: ts_reg};
            S_EU_SUBC: ureq = '{op: UOP_MSUB, x: {1'b0, c0_reg}, y: {1'b0, cs_reg}};
            S_RED_D:   ureq = '{op: UOP_MADD, x: {1'b0, acc_reg}, y: {1'b0, acc_reg}};
            S_RED_A:   ureq = '{op: UOP_MADD, x: {1'b0, acc_reg},
                                y: {31'd0, e_reg[cnt_reg]}};
            S_RED_END: ureq = '{op: UOP_MSUB, x: 32'd0, y: {1'b0, acc_reg}};
            default:   ureq = '{op: UOP_RSUB, x: 32'd0, y: 32'd0};
        endcase
    end

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        ts_next    = ts_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        cs_next    = cs_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        e_next     = e_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                res_next   = 31'd0;
                st_next    = ST_OK;
                state_next = S_DONE;
                acc_next   = 31'd0;
                if (mod_reg == 31'd0) begin
                    st_next = ST_RANGE;
                end else if (item_reg.action <= ACT_DIV && (a_bad || b_bad)) begin
                    st_next = ST_RANGE;
                end else if (item_reg.action != ACT_REDUCE && a_bad) begin
                    st_next = ST_RANGE;
                end else begin
                    unique case (action_t'(item_reg.action))
                        ACT_ADD, ACT_SUB, ACT_NEG: begin
                            res_next = ures[30:0];
                        end
                        ACT_MUL: begin
                            mx_next    = item_reg.left_operand;
                            my_next    = item_reg.right_operand;
                            cnt_next   = 6'd30;
                            state_next = S_MUL_D;
                        end
                        ACT_DIV, ACT_INV: begin
                            s_next     = {1'b0, mod_reg};
                            t_next     = (item_reg.action == ACT_DIV)
                                       ? {1'b0, item_reg.right_operand}
                                       : {1'b0, item_reg.left_operand};
                            c0_next    = 31'd0;
                            c1_next    = one_mod;
                            state_next = S_EU_TEST;
                        end
                        ACT_POW: begin
                            if (item_reg.wide_operand[63]) begin
                                st_next = ST_NEG_EXP;
                            end else begin
                                r_next     = one_mod;
                                x_next     = item_reg.left_operand;
                                e_next     = item_reg.wide_operand;
                                state_next = S_PW_TEST;
                            end
                        end
                        default: begin
                            e_next     = item_reg.wide_operand[63]
                                       ? (~item_reg.wide_operand) + 64'd1
                                       : item_reg.wide_operand;
                            cnt_next   = 6'd63;
                            state_next = S_RED_D;
                        end
                    endcase
                end
            end
            S_MUL_D: begin
                acc_next   = ures[30:0];
                state_next = S_MUL_A;
            end
            S_MUL_A: begin
                acc_next   = ures[30:0];
                state_next = S_MUL_D;
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    if (item_reg.action == ACT_POW) begin
                        if (!phase_reg) begin
                            r_next     = ures[30:0];
                            mx_next    = x_reg;
                            my_next    = x_reg;
                            acc_next   = 31'd0;
                            cnt_next   = 6'd30;
                            phase_next = 1'b1;
                        end else begin
                            x_next     = ures[30:0];
                            e_next     = {1'b0, e_reg[63:1]};
                            state_next = S_PW_TEST;
                        end
                    end else begin
                        res_next   = ures[30:0];
                        state_next = S_DONE;
                    end
                end
            end
            S_PW_TEST: begin
                acc_next = 31'd0;
                cnt_next = 6'd30;
                if (e_reg == 64'd0) begin
                    res_next   = r_reg;
                    state_next = S_DONE;
                end else begin
                    mx_next    = x_reg;
                    my_next    = e_reg[0] ? r_reg : x_reg;
                    phase_next = !e_reg[0];
                    state_next = S_MUL_D;
                end
            end
            S_EU_TEST: begin
                if (t_reg == 32'd0) begin
                    state_next = S_EU_END;
                end else if (uborrow) begin
                    s_next  = t_reg;
                    t_next  = s_reg;
                    c0_next = c1_reg;
                    c1_next = c0_reg;
                end else begin
                    ts_next    = t_reg;
                    cs_next    = c1_reg;
                    state_next = S_EU_GROW;
                end
            end
            S_EU_GROW: begin
                state_next = uborrow ? S_EU_SUB : S_EU_DBL;
            end
            S_EU_DBL: begin
                cs_next    = ures[30:0];
                ts_next    = {ts_reg[30:0], 1'b0};
                state_next = S_EU_GROW;
            end
            S_EU_SUB: begin
                s_next     = ures;
                state_next = S_EU_SUBC;
            end
            S_EU_SUBC: begin
                c0_next    = ures[30:0];
                state_next = S_EU_TEST;
            end
            S_EU_END: begin
                state_next = S_DONE;
                if (s_reg != 32'd1) begin
                    st_next = ST_NO_INV;
                end else if (item_reg.action == ACT_DIV) begin
                    mx_next    = item_reg.left_operand;
                    my_next    = c0_reg;
                    acc_next   = 31'd0;
                    cnt_next   = 6'd30;
                    state_next = S_MUL_D;
                end else begin
                    res_next = c0_reg;
                end
            end
            S_RED_D: begin
                acc_next   = ures[30:0];
                state_next = S_RED_A;
            end
            S_RED_A: begin
                acc_next   = ures[30:0];
                cnt_next   = cnt_reg - 6'd1;
                state_next = (cnt_reg == 6'd0) ? S_RED_END : S_RED_D;
            end
            S_RED_END: begin
                res_next   = item_reg.wide_operand[63] ? ures[30:0] : acc_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mod_reg     <= RESET_MODULUS;
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        ts_reg   <= ts_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        cs_reg   <= cs_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        x_reg    <= x_next;
        e_reg    <= e_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.residue_result <= (st_reg == ST_OK) ? res_reg : 31'd0;
            m_data_reg.status         <= st_reg;
        end
    end

    `MAU_CHECK(a_accept_busy, (s_valid && s_ready) |=> !s_ready)
    `MAU_CHECK(a_err_zero, (m_valid && m_data.status != ST_OK) |-> m_data.residue_result == 31'd0)
    `MAU_CHECK(a_res_range, m_valid |-> (m_data.residue_result < mod_reg || m_data.residue_result == 31'd0))

endmodule
